@@ rtl/ordered_set_gap_tracker_top_defines.svh @@
// Assertion macros shared by the gap tracker checker.
`ifndef ORDERED_SET_GAP_TRACKER_TOP_DEFINES_SVH
`define ORDERED_SET_GAP_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OGT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OGT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ogt_pkg.sv @@
// Package: command codes, answer constants, sequencer states and compare flags.
package ogt_pkg;

    localparam int KEY_PORT_BITS = 31;
    localparam int ANSWER_BITS   = 32;

    typedef enum logic [2:0] {
        CMD_INSERT  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_SEARCH  = 3'd2,
        CMD_MAX_GAP = 3'd3,
        CMD_MIN_GAP = 3'd4
    } cmd_t;

    localparam logic [ANSWER_BITS-1:0] ANSWER_NONE  = 32'hFFFF_FFFF;
    localparam logic [ANSWER_BITS-1:0] ANSWER_MAX   = 32'h7FFF_FFFF;
    localparam logic [ANSWER_BITS-1:0] ANSWER_TRUE  = 32'd1;
    localparam logic [ANSWER_BITS-1:0] ANSWER_FALSE = 32'd0;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_BS_PROBE = 16'h0002,
        ST_BS_CMP   = 16'h0004,
        ST_DECIDE   = 16'h0008,
        ST_INS_RD   = 16'h0010,
        ST_INS_WR   = 16'h0020,
        ST_DEL_RD   = 16'h0040,
        ST_DEL_WR   = 16'h0080,
        ST_MX_RD0   = 16'h0100,
        ST_MX_RDL   = 16'h0200,
        ST_MX_SUB   = 16'h0400,
        ST_MG_RD0   = 16'h0800,
        ST_MG_RD1   = 16'h1000,
        ST_MG_SUB   = 16'h2000,
        ST_MG_CMP   = 16'h4000,
        ST_RESULT   = 16'h8000
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_flags_t;

endpackage

@@ rtl/ogt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ogt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ogt_alu.sv @@
// Shared subtract/compare unit: difference plus less-than and equal flags.
module ogt_alu #(
    parameter int KEY_BITS = 31
) (
    input  logic [KEY_BITS-1:0] a,
    input  logic [KEY_BITS-1:0] b,
    output logic [KEY_BITS-1:0] diff,
    output ogt_pkg::cmp_flags_t flags
);

    logic [KEY_BITS:0] wide_diff;

    // borrow out of the extended subtract is a < b
    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign diff      = wide_diff[KEY_BITS-1:0];
    assign flags.lt  = wide_diff[KEY_BITS];
    assign flags.eq  = (wide_diff == '0);

endmodule

@@ rtl/ordered_set_gap_tracker_top.sv @@
// Sorted key set with search, insert, delete and max/min adjacent gap queries.
// Flow: search/insert/delete first run a binary search, each probe a key RAM read
//   then a compare; insert then shifts entries up one at a time (read, write),
//   delete shifts down likewise; max gap reads first and last key; min gap scans adjacent pairs.
// Throughput: one item at a time; in_stall is high whenever the sequencer is out of idle.
// Reset: count, sequencer and output valid clear; key RAM contents stay undefined, no sweep.
module ordered_set_gap_tracker_top #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           command,
    input  logic [ogt_pkg::KEY_PORT_BITS-1:0]    key,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ogt_pkg::ANSWER_BITS-1:0] answer,
    output logic                                 status
);

    // AW indexes the key RAM; CW holds a count that can reach CAPACITY.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Clamp a gap to the largest positive answer (only matters above 31-bit keys).
    function automatic logic [ogt_pkg::ANSWER_BITS-1:0] sat_gap(
        input logic [KEY_BITS-1:0] v
    );
        logic [KEY_BITS-1:0] upper;
        upper = v >> 31;
        if (upper != '0)
        begin
            return ogt_pkg::ANSWER_MAX;
        end
        return ogt_pkg::ANSWER_BITS'(v);
    endfunction

    ogt_pkg::state_t state_reg, state_next;

    logic [2:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                hit_reg, hit_next;
    // prev_reg: smallest key for max gap, previous key for min gap
    logic [KEY_BITS-1:0] prev_reg, prev_next;
    logic [KEY_BITS-1:0] diff_reg, diff_next;
    logic [KEY_BITS-1:0] best_reg, best_next;

    logic [ogt_pkg::ANSWER_BITS-1:0] res_answer_reg, res_answer_next;
    logic                            res_status_reg, res_status_next;

    logic                            out_valid_reg, out_valid_next;
    logic [ogt_pkg::ANSWER_BITS-1:0] answer_reg, answer_next;
    logic                            status_reg, status_next;

    logic                in_accept;
    logic [KEY_BITS-1:0] key_in;
    logic [CW-1:0]       mid_calc;
    logic [CW-1:0]       idx_plus;
    logic [CW-1:0]       idx_minus;

    // RAM access
    logic                ram_we;
    logic [CW-1:0]       ram_waddr_full;
    logic [KEY_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [CW-1:0]       ram_raddr_full;
    logic [KEY_BITS-1:0] ram_rdata;

    // shared unit
    logic [KEY_BITS-1:0] alu_a;
    logic [KEY_BITS-1:0] alu_b;
    logic [KEY_BITS-1:0] alu_diff;
    ogt_pkg::cmp_flags_t alu_flags;

    assign in_accept = in_valid && (state_reg == ogt_pkg::ST_IDLE);
    assign in_stall  = (state_reg != ogt_pkg::ST_IDLE);
    assign key_in    = KEY_BITS'(key);
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_plus  = idx_reg + CW'(1);
    assign idx_minus = idx_reg - CW'(1);

    ogt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr_full[AW-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr_full[AW-1:0]),
        .rd_data (ram_rdata)
    );

    ogt_alu #(
        .KEY_BITS (KEY_BITS)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    // Operand select for the shared subtract/compare unit.
    always_comb
    begin
        alu_a = ram_rdata;
        alu_b = key_reg;
        unique case (state_reg)
            ogt_pkg::ST_MX_SUB,
            ogt_pkg::ST_MG_SUB:
            begin
                alu_a = ram_rdata;
                alu_b = prev_reg;
            end
            ogt_pkg::ST_MG_CMP:
            begin
                alu_a = diff_reg;
                alu_b = best_reg;
            end
            default:
            begin
                alu_a = ram_rdata;
                alu_b = key_reg;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        prev_next       = prev_reg;
        diff_next       = diff_reg;
        best_next       = best_reg;
        res_answer_next = res_answer_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        answer_next     = answer_reg;
        status_next     = status_reg;

        ram_we          = 1'b0;
        ram_waddr_full  = idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr_full  = mid_calc;

        // output register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ogt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = command;
                    key_next        = key_in;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    hit_next        = 1'b0;
                    res_status_next = ogt_pkg::STATUS_OK;
                    res_answer_next = ogt_pkg::ANSWER_NONE;
                    if (command == ogt_pkg::CMD_INSERT || command == ogt_pkg::CMD_DELETE ||
                        command == ogt_pkg::CMD_SEARCH)
                    begin
                        state_next = ogt_pkg::ST_BS_PROBE;
                    end
                    else if (command == ogt_pkg::CMD_MAX_GAP ||
                             command == ogt_pkg::CMD_MIN_GAP)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            state_next = ogt_pkg::ST_RESULT;
                        end
                        else if (command == ogt_pkg::CMD_MAX_GAP)
                        begin
                            state_next = ogt_pkg::ST_MX_RD0;
                        end
                        else
                        begin
                            state_next = ogt_pkg::ST_MG_RD0;
                        end
                    end
                end
            end

            ogt_pkg::ST_BS_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr_full = mid_calc;
                    mid_next       = mid_calc;
                    state_next     = ogt_pkg::ST_BS_CMP;
                end
                else
                begin
                    state_next = ogt_pkg::ST_DECIDE;
                end
            end

            ogt_pkg::ST_BS_CMP:
            begin
                if (alu_flags.lt)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                if (alu_flags.eq)
                begin
                    hit_next = 1'b1;
                end
                state_next = ogt_pkg::ST_BS_PROBE;
            end

            ogt_pkg::ST_DECIDE:
            begin
                // lo_reg is now the first position whose key is not below the operand
                if (cmd_reg == ogt_pkg::CMD_INSERT)
                begin
                    if (hit_reg)
                    begin
                        state_next = ogt_pkg::ST_IDLE;
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        res_answer_next = ogt_pkg::ANSWER_NONE;
                        res_status_next = ogt_pkg::STATUS_FULL;
                        state_next      = ogt_pkg::ST_RESULT;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = ogt_pkg::ST_INS_RD;
                    end
                end
                else if (cmd_reg == ogt_pkg::CMD_DELETE)
                begin
                    if (hit_reg)
                    begin
                        idx_next   = lo_reg;
                        state_next = ogt_pkg::ST_DEL_RD;
                    end
                    else
                    begin
                        res_answer_next = ogt_pkg::ANSWER_NONE;
                        state_next      = ogt_pkg::ST_RESULT;
                    end
                end
                else
                begin
                    res_answer_next = hit_reg ? ogt_pkg::ANSWER_TRUE : ogt_pkg::ANSWER_FALSE;
                    state_next      = ogt_pkg::ST_RESULT;
                end
            end

            ogt_pkg::ST_INS_RD:
            begin
                if (idx_reg > lo_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr_full = idx_minus;
                    state_next     = ogt_pkg::ST_INS_WR;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_waddr_full = idx_reg;
                    ram_wdata      = key_reg;
                    count_next     = count_reg + CW'(1);
                    state_next     = ogt_pkg::ST_IDLE;
                end
            end

            ogt_pkg::ST_INS_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr_full = idx_reg;
                ram_wdata      = ram_rdata;
                idx_next       = idx_minus;
                state_next     = ogt_pkg::ST_INS_RD;
            end

            ogt_pkg::ST_DEL_RD:
            begin
                if (idx_plus < count_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr_full = idx_plus;
                    state_next     = ogt_pkg::ST_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ogt_pkg::ST_IDLE;
                end
            end

            ogt_pkg::ST_DEL_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr_full = idx_reg;
                ram_wdata      = ram_rdata;
                idx_next       = idx_plus;
                state_next     = ogt_pkg::ST_DEL_RD;
            end

            ogt_pkg::ST_MX_RD0:
            begin
                ram_re         = 1'b1;
                ram_raddr_full = '0;
                state_next     = ogt_pkg::ST_MX_RDL;
            end

            ogt_pkg::ST_MX_RDL:
            begin
                prev_next      = ram_rdata;
                ram_re         = 1'b1;
                ram_raddr_full = count_reg - CW'(1);
                state_next     = ogt_pkg::ST_MX_SUB;
            end

            ogt_pkg::ST_MX_SUB:
            begin
                res_answer_next = sat_gap(alu_diff);
                state_next      = ogt_pkg::ST_RESULT;
            end

            ogt_pkg::ST_MG_RD0:
            begin
                ram_re         = 1'b1;
                ram_raddr_full = '0;
                best_next      = '1;
                state_next     = ogt_pkg::ST_MG_RD1;
            end

            ogt_pkg::ST_MG_RD1:
            begin
                prev_next      = ram_rdata;
                ram_re         = 1'b1;
                ram_raddr_full = CW'(1);
                idx_next       = CW'(1);
                state_next     = ogt_pkg::ST_MG_SUB;
            end

            ogt_pkg::ST_MG_SUB:
            begin
                // gap to the previous key; prefetch the next entry meanwhile
                diff_next = alu_diff;
                prev_next = ram_rdata;
                idx_next  = idx_plus;
                if (idx_plus < count_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr_full = idx_plus;
                end
                state_next = ogt_pkg::ST_MG_CMP;
            end

            ogt_pkg::ST_MG_CMP:
            begin
                if (alu_flags.lt)
                begin
                    best_next = diff_reg;
                end
                if (idx_reg < count_reg)
                begin
                    state_next = ogt_pkg::ST_MG_SUB;
                end
                else
                begin
                    res_answer_next = sat_gap(alu_flags.lt ? diff_reg : best_reg);
                    state_next      = ogt_pkg::ST_RESULT;
                end
            end

            ogt_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    answer_next    = res_answer_reg;
                    status_next    = res_status_reg;
                    state_next     = ogt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ogt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ogt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        prev_reg       <= prev_next;
        diff_reg       <= diff_next;
        best_reg       <= best_next;
        res_answer_reg <= res_answer_next;
        res_status_reg <= res_status_next;
        answer_reg     <= answer_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign answer    = $signed(answer_reg);
    assign status    = status_reg;

endmodule

@@ rtl/ogt_checker.sv @@
// Port-level checker for the gap tracker, bound to the top level.
`include "ordered_set_gap_tracker_top_defines.svh"

module ogt_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic [2:0]                             command,
    input logic [ogt_pkg::KEY_PORT_BITS-1:0]      key,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [ogt_pkg::ANSWER_BITS-1:0] answer,
    input logic                                   status
);

    logic real_cmd;

    assign real_cmd = (command == ogt_pkg::CMD_INSERT) || (command == ogt_pkg::CMD_DELETE) ||
                      (command == ogt_pkg::CMD_SEARCH) || (command == ogt_pkg::CMD_MAX_GAP) ||
                      (command == ogt_pkg::CMD_MIN_GAP);

    // a full-table reject always carries the "none" answer
    `OGT_ASSERT_NOW(a_full_answer, clk, rst_n, out_valid && status, answer == -32'sd1, "full reject without -1 answer")

    // the only negative answer is -1
    `OGT_ASSERT_NOW(a_no_neg, clk, rst_n, out_valid && answer[31], answer == -32'sd1, "negative answer other than -1")

    // an accepted real command takes the block out of idle, which raises in_stall
    `OGT_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall && real_cmd, in_stall, "block free right after a command")

    // a stalled result holds
    `OGT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(answer) && $stable(status), "stalled result changed")

endmodule

bind ordered_set_gap_tracker_top ogt_checker u_ogt_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the ordered set gap tracker: directed, fill, stall and random items.
module testbench;

    // The block's own size, kept at its defaults.
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = ogt_pkg::KEY_PORT_BITS;
    localparam int ANS_W       = ogt_pkg::ANSWER_BITS;

    localparam logic [KEY_W-1:0] KEY_TOP = {KEY_W{1'b1}};

    // Codes above min gap are spare; the block must ignore them.
    localparam logic [2:0] CMD_TOP_CODE = 3'd7;

    // Slowest item: full-depth shift plus search, worst stalls on both sides.
    localparam int ITEM_WORST   = 2 * TABLE_DEPTH + 2 * 9 + 8 + 2 * 10;
    // Four times the worst case over about a thousand items.
    localparam int CYCLE_LIMIT  = 4 * ITEM_WORST * 1000;
    localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 64;
    localparam int RANDOM_ITEMS = 350;
    localparam int POOL_SIZE    = 48;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic [ANS_W-1:0] answer;
        logic             status;
    } expected_answer_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [2:0]              command;
    logic [KEY_W-1:0]        key;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [ANS_W-1:0] answer;
    logic                    status;

    // Shadow of the block's sorted store and the answers still owed.
    logic [KEY_W-1:0]  held_keys[$];
    expected_answer_t  pending_answers[$];

    int error_count     = 0;
    int cycle_count     = 0;
    int in_gap_max      = 10;
    int out_gap_max     = 10;
    int hold_off_cycles = 0;

    ordered_set_gap_tracker_top #(
        .CAPACITY (TABLE_DEPTH),
        .KEY_BITS (KEY_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .answer    (answer),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: applies one accepted command to the shadow set and
    // queues the answer it owes, if any.
    // ------------------------------------------------------------------
    function automatic void apply_command(input logic [2:0] cmd, input logic [KEY_W-1:0] k);
        int               pos;
        bit               present;
        logic [ANS_W-1:0] best;
        logic [ANS_W-1:0] diff;
        expected_answer_t owed;

        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < k)
            pos++;
        present     = (pos < held_keys.size()) && (held_keys[pos] == k);
        owed.status = ogt_pkg::STATUS_OK;

        case (cmd)
            ogt_pkg::CMD_INSERT:
            begin
                // Duplicate insert is silent even when the table is full.
                if (!present)
                begin
                    if (held_keys.size() >= TABLE_DEPTH)
                    begin
                        owed.answer = ogt_pkg::ANSWER_NONE;
                        owed.status = ogt_pkg::STATUS_FULL;
                        pending_answers.push_back(owed);
                    end
                    else
                    begin
                        held_keys.insert(pos, k);
                    end
                end
            end
            ogt_pkg::CMD_DELETE:
            begin
                if (present)
                begin
                    held_keys.delete(pos);
                end
                else
                begin
                    owed.answer = ogt_pkg::ANSWER_NONE;
                    pending_answers.push_back(owed);
                end
            end
            ogt_pkg::CMD_SEARCH:
            begin
                owed.answer = present ? ogt_pkg::ANSWER_TRUE : ogt_pkg::ANSWER_FALSE;
                pending_answers.push_back(owed);
            end
            ogt_pkg::CMD_MAX_GAP:
            begin
                if (held_keys.size() < 2)
                    owed.answer = ogt_pkg::ANSWER_NONE;
                else
                    owed.answer = {1'b0, held_keys[held_keys.size() - 1] - held_keys[0]};
                pending_answers.push_back(owed);
            end
            ogt_pkg::CMD_MIN_GAP:
            begin
                if (held_keys.size() < 2)
                begin
                    owed.answer = ogt_pkg::ANSWER_NONE;
                end
                else
                begin
                    best = {1'b0, held_keys[1] - held_keys[0]};
                    for (int i = 2; i < held_keys.size(); i++)
                    begin
                        diff = {1'b0, held_keys[i] - held_keys[i - 1]};
                        if (diff < best)
                            best = diff;
                    end
                    owed.answer = best;
                end
                pending_answers.push_back(owed);
            end
            default:
            begin
                // spare code: no answer, no change
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [ANS_W-1:0] got,
                                   input logic [ANS_W-1:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers one item after a random idle gap, holds it until
    // accepted, then updates the prediction. Valid stays high across
    // back-to-back items so it never gets two updates in one step.
    // ------------------------------------------------------------------
    task automatic send_command(input logic [2:0] cmd, input logic [KEY_W-1:0] k);
        int gap;

        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        apply_command(cmd, k);
    endtask

    // Sender goes quiet until every owed answer is back.
    task automatic drain_answers();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stall per item, with the stall starting before
    // the result shows up so gaps land on every phase. A long hold-off,
    // when requested, is counted here in cycles.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_n;

        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
                out_stall <= 1'b0;
            end
            stall_n = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
            @(negedge clk);
            out_stall <= (stall_n > 0);
            if (stall_n > 0)
            begin
                do
                    @(posedge clk);
                while (!out_valid);
                repeat (stall_n) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Checker: every accepted result against the oldest owed answer.
    always @(posedge clk)
    begin
        expected_answer_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("result with no answer owed", answer, '0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (answer !== want.answer)
                    report_mismatch("answer", answer, want.answer);
                if (status !== want.status)
                    report_mismatch("status", {31'b0, status}, {31'b0, want.status});
            end
        end
    end

    // Watchdog: counts cycles and ends a hung run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries on an empty set, absent delete, and the spare codes.
    task automatic test_empty_set();
        send_command(ogt_pkg::CMD_SEARCH, '0);
        send_command(ogt_pkg::CMD_MAX_GAP, KEY_TOP);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_DELETE, KEY_TOP);
        for (int c = ogt_pkg::CMD_MIN_GAP + 1; c <= CMD_TOP_CODE; c++)
            send_command(3'(c), (c % 2) ? KEY_TOP : '0);
        send_command(ogt_pkg::CMD_MAX_GAP, '0);
    endtask

    // Key extremes, one-key set, duplicate insert, gap of one, delete of the max.
    task automatic test_key_extremes();
        send_command(ogt_pkg::CMD_INSERT, '0);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_INSERT, KEY_TOP);
        send_command(ogt_pkg::CMD_SEARCH, '0);
        send_command(ogt_pkg::CMD_SEARCH, KEY_TOP);
        send_command(ogt_pkg::CMD_SEARCH, 31'd1);
        send_command(ogt_pkg::CMD_MAX_GAP, '0);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_INSERT, '0);
        send_command(ogt_pkg::CMD_INSERT, 31'd1);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        // Removing the max must drop exactly one gap from the tracking.
        send_command(ogt_pkg::CMD_DELETE, KEY_TOP);
        send_command(ogt_pkg::CMD_MAX_GAP, '0);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_INSERT, 31'h5555_5555);
        send_command(ogt_pkg::CMD_INSERT, 31'h2AAA_AAAA);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_DELETE, '0);
        send_command(ogt_pkg::CMD_DELETE, '0);
        send_command(ogt_pkg::CMD_DELETE, 31'd1);
        send_command(ogt_pkg::CMD_DELETE, 31'h5555_5555);
        send_command(ogt_pkg::CMD_DELETE, 31'h2AAA_AAAA);
        send_command(ogt_pkg::CMD_MAX_GAP, '0);
    endtask

    // Fill to capacity in shuffled order, hit the full cases, then empty it.
    task automatic test_full_table();
        int               stripe[TABLE_DEPTH];
        int               j;
        int               tmp;
        int               n;
        logic [KEY_W-1:0] k;

        for (int i = 0; i < TABLE_DEPTH; i++)
            stripe[i] = i;
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            j         = $urandom_range(0, i);
            tmp       = stripe[i];
            stripe[i] = stripe[j];
            stripe[j] = tmp;
        end
        // One key per 2^23-wide stripe keeps them distinct across the range.
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            k = {stripe[i][7:0], 23'($urandom)};
            send_command(ogt_pkg::CMD_INSERT, k);
            if (i % 64 == 63)
                send_command(ogt_pkg::CMD_MIN_GAP, '0);
        end
        drain_answers();

        send_command(ogt_pkg::CMD_INSERT, KEY_W'($urandom));
        send_command(ogt_pkg::CMD_INSERT, held_keys[$urandom_range(0, TABLE_DEPTH - 1)]);
        send_command(ogt_pkg::CMD_SEARCH, held_keys[TABLE_DEPTH - 1]);
        send_command(ogt_pkg::CMD_MAX_GAP, '0);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_DELETE, held_keys[held_keys.size() - 1]);
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
        send_command(ogt_pkg::CMD_INSERT, KEY_TOP);
        send_command(ogt_pkg::CMD_INSERT, KEY_W'($urandom));
        send_command(ogt_pkg::CMD_MAX_GAP, '0);

        n = 0;
        while (held_keys.size() > 0)
        begin
            send_command(ogt_pkg::CMD_DELETE,
                         held_keys[$urandom_range(0, held_keys.size() - 1)]);
            n++;
            if (n % 32 == 0)
                send_command(ogt_pkg::CMD_MIN_GAP, '0);
        end
        send_command(ogt_pkg::CMD_MIN_GAP, '0);
    endtask

    // Long receiver hold-off while the sender keeps offering items back to back.
    task automatic test_backpressure();
        in_gap_max = 0;
        send_command(ogt_pkg::CMD_INSERT, 31'd100);
        send_command(ogt_pkg::CMD_INSERT, 31'd160);
        hold_off_cycles = 1500;
        for (int i = 0; i < 30; i++)
        begin
            case (i % 3)
                0: send_command(ogt_pkg::CMD_SEARCH, (i % 2) ? 31'd100 : 31'd101);
                1: send_command(ogt_pkg::CMD_MAX_GAP, '0);
                default: send_command(ogt_pkg::CMD_MIN_GAP, '0);
            endcase
        end
        drain_answers();
        send_command(ogt_pkg::CMD_DELETE, 31'd100);
        send_command(ogt_pkg::CMD_DELETE, 31'd160);
        in_gap_max = 10;
    endtask

    // Mixed random traffic over a small key pool so hits are common,
    // plus full-width keys for bit coverage.
    task automatic test_random_traffic();
        logic [KEY_W-1:0] key_pool[POOL_SIZE];
        logic [2:0]       cmd;
        logic [KEY_W-1:0] k;
        int               sent;
        int               r;

        key_pool[0] = '0;
        key_pool[1] = 31'd1;
        key_pool[2] = KEY_TOP;
        key_pool[3] = KEY_TOP - KEY_W'(1);
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            if (i % 4 == 0)
                key_pool[i] = key_pool[i - 1] + KEY_W'(1);
            else
                key_pool[i] = KEY_W'($urandom) & (KEY_TOP >> $urandom_range(0, KEY_W - 1));
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Switch pacing every 50 items: bursts with no idling, or random gaps.
            if (sent % 50 == 0)
            begin
                in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 10;
                out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            end
            r = $urandom_range(0, 99);
            if (r < 30)
                cmd = ogt_pkg::CMD_INSERT;
            else if (r < 55)
                cmd = ogt_pkg::CMD_DELETE;
            else if (r < 70)
                cmd = ogt_pkg::CMD_SEARCH;
            else if (r < 80)
                cmd = ogt_pkg::CMD_MAX_GAP;
            else if (r < 93)
                cmd = ogt_pkg::CMD_MIN_GAP;
            else
                cmd = 3'($urandom_range(ogt_pkg::CMD_MIN_GAP + 1, CMD_TOP_CODE));

            if ($urandom_range(0, 9) < 7)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = KEY_W'($urandom);

            send_command(cmd, k);
            if (cmd <= ogt_pkg::CMD_MIN_GAP)
                sent++;
            if (sent % 200 == 199)
                drain_answers();
        end
        in_gap_max  = 10;
        out_gap_max = 10;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        in_valid = 1'b0;
        command  = '0;
        key      = '0;
        rst_n    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_set();
        test_key_extremes();
        drain_answers();
        test_full_table();
        drain_answers();
        test_backpressure();
        test_random_traffic();

        drain_answers();
        // Trailing inserts owe nothing but may still be running.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
